/* src/table_cubic_lagrange_interp_core_macros.svh */
// Assertion helpers used by the checker file.
`ifndef TABLE_CUBIC_LAGRANGE_INTERP_CORE_MACROS_SVH
`define TABLE_CUBIC_LAGRANGE_INTERP_CORE_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define TLCI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication across a fixed number of cycles, held off while reset is high.
`define TLCI_ASSERT_DLY(label, clk, rst, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

/* src/tlci_pkg.sv */
package tlci_pkg;

  // Store organisation
  localparam int CURVES      = 64;
  localparam int POINTS      = 1024;
  localparam int STORE_DEPTH = CURVES * POINTS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BANKS       = 4;
  localparam int ROW_W       = ADDR_W - 2;
  localparam int BANK_DEPTH  = 1 << ROW_W;

  // Field widths
  localparam int CURVE_IDX_W = 6;
  localparam int POINT_IDX_W = 10;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 32;
  localparam int STEP_W      = 32;
  localparam int MESH_W      = 11;
  localparam int COORD_W     = POS_W + STEP_W;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_STEP    = 1'b0,
    REG_MESH_POINTS = 1'b1
  } cfg_reg_t;
  localparam logic [STEP_W-1:0] INV_STEP_RESET = 32'd65536;
  localparam logic [MESH_W-1:0] MESH_RESET     = 11'd1024;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Weight arithmetic: t in Q0.16, a = 1-t, b = 2-t, c = 3-t
  localparam int FRAC_W   = 16;
  localparam int A_W      = 17;
  localparam int BC_W     = 18;
  localparam int ONE_Q16  = 65536;
  localparam int TWO_Q16  = 2 * ONE_Q16;
  localparam int THREE_Q16 = 3 * ONE_Q16;
  localparam int AB_W     = A_W + BC_W;
  localparam int TA_W     = FRAC_W + A_W;
  localparam int TB_W     = FRAC_W + BC_W;
  localparam int NUM_W    = AB_W + BC_W;
  localparam int SUM_W    = NUM_W + 1;
  localparam int WEIGHT_W = 30;

  // Rounded division of a Q.48 product down to Q2.28
  localparam int DIV2_SHIFT = 21;           // divide by 2 * 2^20
  localparam int DIV6_PRE   = 21;           // divide by 2 * 2^20, then by 3
  localparam int RECIP_W    = 32;
  localparam logic [RECIP_W-1:0] RECIP3 = 32'hAAAA_AAAB;
  localparam int RECIP3_SHIFT = 33;
  localparam logic [SUM_W-1:0] BIAS_DIV2 = SUM_W'(64'd1 << 20);
  localparam logic [SUM_W-1:0] BIAS_DIV6 = SUM_W'(64'd3 << 20);

  // Accumulation and final rounding
  localparam int ACC_W     = 64;
  localparam int OUT_SHIFT = 28;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd134217728;
  localparam logic signed [ACC_W-1:0] SAT_MAX    = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN    = -64'sd2147483648;

  // Cycles from an accepted query to its result strobe
  localparam int LATENCY = 8;

endpackage

/* src/tlci_ram.sv */
module tlci_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/table_cubic_lagrange_interp_core.sv */
// Channel | Handshake            | Fields
// request | start, busy          | opcode, curve_index, point_index, entry_value, query_position
// result  | done (one cycle)     | interpolated_value, out_of_range
// config  | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// One request per cycle while busy is low. A query passes through the
// input register, grid product, bank read with the first weight products, second
// weight product, weight division, sample products and two add stages. A write gives
// no result and lands in the store at the same stage as query reads, so order is kept.
// busy is high during reset and in the cycle after it; the store is not cleared.
// Results cannot be stalled.
module table_cubic_lagrange_interp_core
  import tlci_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [CURVE_IDX_W-1:0]        curve_index,
  input  logic [POINT_IDX_W-1:0]        point_index,
  input  logic signed [DATA_W-1:0]      entry_value,
  input  logic [POS_W-1:0]              query_position,
  output logic                          done,
  output logic signed [DATA_W-1:0]      interpolated_value,
  output logic                          out_of_range,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [STEP_W-1:0]             cfg_data
);

  logic              accept;
  logic [STEP_W-1:0] inv_step;
  logic [MESH_W-1:0] mesh_points;

  // stage 1
  logic                     v1;
  logic                     op1;
  logic [CURVE_IDX_W-1:0]   curve1;
  logic [POINT_IDX_W-1:0]   point1;
  logic signed [DATA_W-1:0] value1;
  logic [POS_W-1:0]         pos1;
  logic [COORD_W-1:0]       coord1;

  // stage 2
  logic                     v2;
  logic                     op2;
  logic [CURVE_IDX_W-1:0]   curve2;
  logic [POINT_IDX_W-1:0]   point2;
  logic signed [DATA_W-1:0] value2;
  logic [COORD_W-1:0]       coord2;
  logic [31:0]              iq2;
  logic [FRAC_W-1:0]        t2;
  logic [31:0]              used2;
  logic                     bad2;
  logic [31:0]              base_full2;
  logic [ADDR_W-1:0]        base2;
  logic [31:0]              waddr_full2;
  logic [ADDR_W-1:0]        waddr2;
  logic                     wr_ok2;
  logic                     rd_en2;
  logic [A_W-1:0]           a2;
  logic [BC_W-1:0]          b2;
  logic [BC_W-1:0]          c2;

  // stage 3
  logic                     q3;
  logic                     bad3;
  logic [1:0]               sel3;
  logic [AB_W-1:0]          ab3;
  logic [TA_W-1:0]          ta3;
  logic [TB_W-1:0]          tb3;
  logic [BC_W-1:0]          b3;
  logic [BC_W-1:0]          c3;
  logic signed [DATA_W-1:0] e3 [BANKS];

  // stage 4
  logic                     q4;
  logic                     bad4;
  logic [NUM_W-1:0]         n4 [BANKS];
  logic signed [DATA_W-1:0] e4 [BANKS];
  logic [SUM_W-1:0]         x4 [BANKS];
  logic [2*RECIP_W-1:0]     r0_4;
  logic [2*RECIP_W-1:0]     r3_4;
  logic [WEIGHT_W-1:0]      w4 [BANKS];

  // stage 5
  logic                     q5;
  logic                     bad5;
  logic [WEIGHT_W-1:0]      w5 [BANKS];
  logic signed [DATA_W-1:0] e5 [BANKS];

  // stage 6
  logic                     q6;
  logic                     bad6;
  logic signed [ACC_W-1:0]  m6 [BANKS];

  // stage 7
  logic                     q7;
  logic                     bad7;
  logic signed [ACC_W-1:0]  sum01_7;
  logic signed [ACC_W-1:0]  sum23_7;
  logic signed [ACC_W-1:0]  acc7;
  logic signed [ACC_W-1:0]  shifted7;
  logic signed [DATA_W-1:0] sat7;

  // banks
  logic                     bank_we    [BANKS];
  logic [ROW_W-1:0]         bank_waddr [BANKS];
  logic [ROW_W-1:0]         bank_raddr [BANKS];
  logic [DATA_W-1:0]        bank_q     [BANKS];

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  // busy stays high in the cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_step    <= INV_STEP_RESET;
      mesh_points <= MESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_INV_STEP:    inv_step    <= cfg_data;
        REG_MESH_POINTS: mesh_points <= cfg_data[MESH_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: capture request
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    op1    <= opcode;
    curve1 <= curve_index;
    point1 <= point_index;
    value1 <= entry_value;
    pos1   <= query_position;
  end

  // grid coordinate, Q32.32
  assign coord1 = pos1 * inv_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    op2    <= op1;
    curve2 <= curve1;
    point2 <= point1;
    value2 <= value1;
    coord2 <= coord1;
  end

  // stage 2: index split, range check, bank addressing, first weight factors
  always_comb begin
    iq2   = coord2[COORD_W-1:32];
    t2    = coord2[31:32-FRAC_W];
    used2 = (32'(mesh_points) < 32'(POINTS)) ? 32'(mesh_points) : 32'(POINTS);
    bad2  = (32'(curve2) >= 32'(CURVES)) || (used2 <= 32'd4) || (iq2 >= used2 - 32'd4);

    base_full2  = 32'(curve2) * 32'(POINTS) + iq2;
    base2       = base_full2[ADDR_W-1:0];
    waddr_full2 = 32'(curve2) * 32'(POINTS) + 32'(point2);
    waddr2      = waddr_full2[ADDR_W-1:0];

    wr_ok2 = v2 && (op2 == OP_WRITE) && (32'(curve2) < 32'(CURVES))
             && (32'(point2) < 32'(POINTS));
    rd_en2 = v2 && (op2 == OP_QUERY) && !bad2;

    a2 = A_W'(ONE_Q16) - A_W'(t2);
    b2 = BC_W'(TWO_Q16) - BC_W'(t2);
    c2 = BC_W'(THREE_Q16) - BC_W'(t2);
  end

  // four banks: sample k of the row sits in bank (address mod 4), so the four
  // samples of a query come out in the same read cycle
  for (genvar j = 0; j < BANKS; j++) begin : g_bank
    logic [1:0]        off;
    logic [ADDR_W-1:0] raddr_full;

    assign off           = 2'(j) - base2[1:0];
    assign raddr_full    = base2 + ADDR_W'(off);
    assign bank_raddr[j] = raddr_full[ADDR_W-1:2];
    assign bank_waddr[j] = waddr2[ADDR_W-1:2];
    assign bank_we[j]    = wr_ok2 && (waddr2[1:0] == 2'(j));

    tlci_ram #(
      .DEPTH (BANK_DEPTH),
      .WIDTH (DATA_W)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[j]),
      .waddr (bank_waddr[j]),
      .wdata (value2),
      .re    (rd_en2),
      .raddr (bank_raddr[j]),
      .rdata (bank_q[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q3 <= 1'b0;
    end else begin
      q3 <= v2 && (op2 == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    bad3 <= bad2;
    sel3 <= base2[1:0];
    ab3  <= a2 * b2;
    ta3  <= t2 * a2;
    tb3  <= t2 * b2;
    b3   <= b2;
    c3   <= c2;
  end

  // stage 3: put samples in row order, full weight numerators
  always_comb begin
    for (int m = 0; m < BANKS; m++) begin
      e3[m] = bank_q[sel3 + 2'(m)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q4 <= 1'b0;
    end else begin
      q4 <= q3;
    end
  end

  always_ff @(posedge clk) begin
    bad4  <= bad3;
    n4[0] <= ab3 * c3;
    n4[1] <= tb3 * c3;
    n4[2] <= ta3 * c3;
    n4[3] <= ta3 * b3;
    e4    <= e3;
  end

  // stage 4: rounded division to Q2.28 (by 6 for outer weights, by 2 for inner)
  always_comb begin
    x4[0] = SUM_W'(n4[0]) + BIAS_DIV6;
    x4[1] = SUM_W'(n4[1]) + BIAS_DIV2;
    x4[2] = SUM_W'(n4[2]) + BIAS_DIV2;
    x4[3] = SUM_W'(n4[3]) + BIAS_DIV6;
    // divide by 3 through the reciprocal, exact for 32-bit dividends
    r0_4  = x4[0][DIV6_PRE +: RECIP_W] * RECIP3;
    r3_4  = x4[3][DIV6_PRE +: RECIP_W] * RECIP3;
    w4[0] = r0_4[RECIP3_SHIFT +: WEIGHT_W];
    w4[1] = x4[1][DIV2_SHIFT +: WEIGHT_W];
    w4[2] = x4[2][DIV2_SHIFT +: WEIGHT_W];
    w4[3] = r3_4[RECIP3_SHIFT +: WEIGHT_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q5 <= 1'b0;
    end else begin
      q5 <= q4;
    end
  end

  always_ff @(posedge clk) begin
    bad5 <= bad4;
    w5   <= w4;
    e5   <= e4;
  end

  // stage 5: sample times weight
  always_ff @(posedge clk) begin
    if (rst) begin
      q6 <= 1'b0;
    end else begin
      q6 <= q5;
    end
  end

  always_ff @(posedge clk) begin
    bad6 <= bad5;
    for (int k = 0; k < BANKS; k++) begin
      m6[k] <= e5[k] * $signed({1'b0, w5[k]});
    end
  end

  // stage 6: pairwise sums, third term enters negated
  always_ff @(posedge clk) begin
    if (rst) begin
      q7 <= 1'b0;
    end else begin
      q7 <= q6;
    end
  end

  always_ff @(posedge clk) begin
    bad7    <= bad6;
    sum01_7 <= m6[0] + m6[1];
    sum23_7 <= m6[3] - m6[2];
  end

  // stage 7: final sum, round off the Q2.28 weight fraction, saturate
  always_comb begin
    acc7     = sum01_7 + sum23_7 + ROUND_HALF;
    shifted7 = acc7 >>> OUT_SHIFT;
    if (shifted7 > SAT_MAX) begin
      sat7 = SAT_MAX[DATA_W-1:0];
    end else if (shifted7 < SAT_MIN) begin
      sat7 = SAT_MIN[DATA_W-1:0];
    end else begin
      sat7 = shifted7[DATA_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q7;
    end
  end

  always_ff @(posedge clk) begin
    out_of_range       <= bad7;
    interpolated_value <= bad7 ? '0 : sat7;
  end

endmodule

/* src/tlci_checker.sv */
`include "table_cubic_lagrange_interp_core_macros.svh"

module tlci_checker
  import tlci_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     opcode,
  input logic                     done,
  input logic                     out_of_range,
  input logic signed [DATA_W-1:0] interpolated_value
);

  // a rejected query carries a zero value
  `TLCI_ASSERT_IMP(a_oor_zero, clk, rst, done && out_of_range, interpolated_value == '0, "out of range result with nonzero value")

  // every strobe traces back to a query accepted a fixed time before
  `TLCI_ASSERT_IMP(a_done_has_query, clk, rst, done, $past(start && !busy && (opcode == OP_QUERY), LATENCY), "result without a query")

  // every query gives its result after the fixed latency
  `TLCI_ASSERT_DLY(a_query_done, clk, rst, start && !busy && (opcode == OP_QUERY), LATENCY, done, "query result missing")

  // a table write gives no result
  `TLCI_ASSERT_DLY(a_write_silent, clk, rst, start && !busy && (opcode == OP_WRITE), LATENCY, !done, "write produced a result")

endmodule

bind table_cubic_lagrange_interp_core tlci_checker u_tlci_checker (
  .clk                (clk),
  .rst                (rst),
  .start              (start),
  .busy               (busy),
  .opcode             (opcode),
  .done               (done),
  .out_of_range       (out_of_range),
  .interpolated_value (interpolated_value)
);
